// ----- hdl/cat_pkg.sv -----
package cat_pkg;

  // Defaults and fixed field widths
  localparam int unsigned MaxIdDef = 1024;
  localparam int unsigned IdW      = 16;
  localparam int unsigned MarkOutW = 11;
  localparam int unsigned StatusW  = 2;

  // Bitmap word geometry
  localparam int unsigned WordW = 32;
  localparam int unsigned BitAw = 5;

  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_RANGE     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_ADV_RD,
    S_ADV_USE,
    S_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clear_row;
    logic take;
    logic check;
    logic adv_rd;
    logic adv_use;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic id_bad;
    logic chk_more;
    logic adv_more;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/cat_if.sv -----
interface cat_ack_if;
  logic                        valid;
  logic                        ready;
  logic [cat_pkg::IdW-1:0]     ack_id;

  modport source (output valid, output ack_id, input ready);
  modport sink   (input valid, input ack_id, output ready);
endinterface

interface cat_res_if;
  logic                        valid;
  logic                        ready;
  logic [cat_pkg::MarkOutW-1:0] max_contiguous;
  logic [cat_pkg::StatusW-1:0]  status;

  modport source (output valid, output max_contiguous, output status, input ready);
  modport sink   (input valid, input max_contiguous, input status, output ready);
endinterface

// ----- hdl/cat_ctrl.sv -----
module cat_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          ack_valid_i,
  input  cat_pkg::sts_t sts_i,
  output logic          ack_ready_o,
  output cat_pkg::cmd_t cmd_o
);

  cat_pkg::state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cat_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cat_pkg::S_CLEAR: begin
        if (sts_i.clear_last) state_d = cat_pkg::S_IDLE;
      end
      cat_pkg::S_IDLE: begin
        if (ack_valid_i) begin
          if (!sts_i.id_bad) begin
            state_d = cat_pkg::S_CHECK;
          end else if (!sts_i.out_free) begin
            state_d = cat_pkg::S_DONE;
          end
        end
      end
      cat_pkg::S_CHECK: begin
        if (sts_i.chk_more) begin
          state_d = cat_pkg::S_ADV_RD;
        end else begin
          state_d = sts_i.out_free ? cat_pkg::S_IDLE : cat_pkg::S_DONE;
        end
      end
      cat_pkg::S_ADV_RD: begin
        state_d = cat_pkg::S_ADV_USE;
      end
      cat_pkg::S_ADV_USE: begin
        if (sts_i.adv_more) begin
          state_d = cat_pkg::S_ADV_RD;
        end else begin
          state_d = sts_i.out_free ? cat_pkg::S_IDLE : cat_pkg::S_DONE;
        end
      end
      cat_pkg::S_DONE: begin
        if (sts_i.out_free) state_d = cat_pkg::S_IDLE;
      end
      default: begin
        state_d = cat_pkg::S_CLEAR;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd_o       = '0;
    ack_ready_o = 1'b0;
    case (state_q)
      cat_pkg::S_CLEAR: begin
        cmd_o.clear_row = 1'b1;
      end
      cat_pkg::S_IDLE: begin
        ack_ready_o    = 1'b1;
        cmd_o.take     = ack_valid_i;
        cmd_o.load_out = ack_valid_i && sts_i.id_bad && sts_i.out_free;
      end
      cat_pkg::S_CHECK: begin
        cmd_o.check    = 1'b1;
        cmd_o.load_out = !sts_i.chk_more && sts_i.out_free;
      end
      cat_pkg::S_ADV_RD: begin
        cmd_o.adv_rd = 1'b1;
      end
      cat_pkg::S_ADV_USE: begin
        cmd_o.adv_use  = 1'b1;
        cmd_o.load_out = !sts_i.adv_more && sts_i.out_free;
      end
      cat_pkg::S_DONE: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // The check step only follows an accepted transaction
  a_check_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cat_pkg::S_CHECK |-> $past(state_q) == cat_pkg::S_IDLE)
    else $error("check step entered without an accepted transaction");

  // Every scan step uses a word that was just read
  a_use_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cat_pkg::S_ADV_USE |-> $past(state_q) == cat_pkg::S_ADV_RD)
    else $error("scan step without a preceding read");

endmodule

// ----- hdl/cat_dpath.sv -----
module cat_dpath #(
  parameter int unsigned MaxId = cat_pkg::MaxIdDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cat_pkg::cmd_t                cmd_i,
  output cat_pkg::sts_t                sts_o,
  input  logic [cat_pkg::IdW-1:0]      ack_id_i,
  input  logic                         res_ready_i,
  output logic                         res_valid_o,
  output logic [cat_pkg::MarkOutW-1:0] res_max_contiguous_o,
  output logic [cat_pkg::StatusW-1:0]  res_status_o
);

  localparam int unsigned WordW = cat_pkg::WordW;
  localparam int unsigned BitAw = cat_pkg::BitAw;
  localparam int unsigned IdW   = cat_pkg::IdW;
  localparam int unsigned Rows  = (MaxId + WordW - 1) / WordW;
  localparam int unsigned RowAw = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned MarkW = $clog2(MaxId + 1);
  localparam int unsigned NextW = RowAw + BitAw + 1;
  localparam int unsigned ExtW  = MarkW + IdW + NextW + cat_pkg::MarkOutW;

  localparam logic [NextW-1:0] MaxIdN  = NextW'(MaxId);
  localparam logic [IdW:0]     MaxIdI  = (IdW + 1)'(MaxId);
  localparam logic [MarkW-1:0] MaxIdM  = MarkW'(MaxId);
  localparam logic [RowAw-1:0] LastRow = RowAw'(Rows - 1);

  // Bitmap storage, one word per row
  logic [WordW-1:0] mem [Rows];
  logic [WordW-1:0] rdata_q;

  logic [RowAw-1:0]         clr_cnt_q, clr_cnt_d;
  logic [IdW-1:0]           idm1_q;
  logic [MarkW-1:0]         mark_q, mark_d;
  cat_pkg::status_e         status_q, status_d;
  logic                     res_valid_q, res_valid_d;
  logic [cat_pkg::MarkOutW-1:0] res_mark_q;
  logic [cat_pkg::StatusW-1:0]  res_status_q;

  logic [IdW-1:0]   idm1_in;
  logic [ExtW-1:0]  in_ext, id_ext, mark_ext, mark_d_ext;
  logic [RowAw-1:0] in_row, id_row, mark_row;
  logic [BitAw-1:0] id_bit, mark_bit, pos;
  logic             id_bad, dup, hit, found, at_end, cont;
  logic [WordW-1:0] set_word, scan_word, masked;
  logic [NextW-1:0] next_raw, next_mark;

  // Split numbers into row and bit
  always_comb begin
    idm1_in  = ack_id_i - IdW'(1);
    in_ext   = ExtW'(idm1_in);
    id_ext   = ExtW'(idm1_q);
    mark_ext = ExtW'(mark_q);
    in_row   = in_ext[RowAw+BitAw-1:BitAw];
    id_row   = id_ext[RowAw+BitAw-1:BitAw];
    id_bit   = id_ext[BitAw-1:0];
    mark_row = mark_ext[RowAw+BitAw-1:BitAw];
    mark_bit = mark_ext[BitAw-1:0];
  end

  // Classify the transaction
  assign id_bad   = (ack_id_i == '0) || ({1'b0, ack_id_i} > MaxIdI);
  assign dup      = rdata_q[id_bit];
  assign hit      = (id_ext == mark_ext);
  assign set_word = rdata_q | (WordW'(1) << id_bit);

  // Find the first clear bit at or above the mark within its word
  always_comb begin
    scan_word = cmd_i.check ? set_word : rdata_q;
    masked    = scan_word | ((WordW'(1) << mark_bit) - WordW'(1));
    found     = 1'b0;
    pos       = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (!masked[i]) begin
        found = 1'b1;
        pos   = BitAw'(i);
      end
    end
    if (found) begin
      next_raw = NextW'({mark_row, pos});
    end else begin
      next_raw = {({1'b0, mark_row} + (RowAw + 1)'(1)), {BitAw{1'b0}}};
    end
    at_end    = (next_raw >= MaxIdN);
    next_mark = at_end ? MaxIdN : next_raw;
    cont      = !found && !at_end;
  end

  // Status to the controller
  always_comb begin
    sts_o.clear_last = (clr_cnt_q == LastRow);
    sts_o.id_bad     = id_bad;
    sts_o.chk_more   = !dup && hit && cont;
    sts_o.adv_more   = cont;
    sts_o.out_free   = !res_valid_q || res_ready_i;
  end

  // Next mark, status and counters
  always_comb begin
    mark_d = mark_q;
    if ((cmd_i.check && !dup && hit) || cmd_i.adv_use) begin
      mark_d = next_mark[MarkW-1:0];
    end
    status_d = status_q;
    if (cmd_i.take && id_bad) begin
      status_d = cat_pkg::ST_RANGE;
    end else if (cmd_i.check) begin
      status_d = dup ? cat_pkg::ST_DUPLICATE : cat_pkg::ST_ACCEPTED;
    end
    clr_cnt_d  = cmd_i.clear_row ? clr_cnt_q + RowAw'(1) : clr_cnt_q;
    mark_d_ext = ExtW'(mark_d);
    if (cmd_i.load_out) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      mark_q      <= '0;
      status_q    <= cat_pkg::ST_ACCEPTED;
      res_valid_q <= 1'b0;
    end else begin
      clr_cnt_q   <= clr_cnt_d;
      mark_q      <= mark_d;
      status_q    <= status_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      idm1_q <= idm1_in;
    end
    if (cmd_i.load_out) begin
      res_mark_q   <= mark_d_ext[cat_pkg::MarkOutW-1:0];
      res_status_q <= status_d;
    end
  end

  // Bitmap: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_row) begin
      mem[clr_cnt_q] <= '0;
    end else if (cmd_i.check && !dup) begin
      mem[id_row] <= set_word;
    end
    if (cmd_i.take && !id_bad) begin
      rdata_q <= mem[in_row];
    end else if (cmd_i.adv_rd) begin
      rdata_q <= mem[mark_row];
    end
  end

  assign res_valid_o          = res_valid_q;
  assign res_max_contiguous_o = res_mark_q;
  assign res_status_o         = res_status_q;

  a_mark_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_q <= MaxIdM)
    else $error("contiguous mark beyond the last number");

  a_mark_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> mark_q >= $past(mark_q))
    else $error("contiguous mark moved backward");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!res_valid_q || res_ready_i))
    else $error("pending result overwritten");

endmodule

// ----- hdl/cumulative_ack_tracker_top.sv -----
// Channel  Dir  Modport  Payload                        Transaction when
// ack_i    in   sink     ack_id[15:0]                   valid && ready
// res_o    out  source   max_contiguous[10:0] status    valid && ready
//
// An out-of-range number is answered without a bitmap read. An in-range number
// is accepted, then checked against its bitmap word; when it lands on the mark,
// each further bitmap word the mark crosses adds one registered read of the
// bitmap RAM plus a find-first-zero over 32 bits.
// After reset a clearing pass zeroes the ceil(MaxId/32) bitmap rows in turn; no
// transaction is taken meanwhile. One result register sits on res_o: a new
// transaction is taken while a result waits, and the block holds its finished
// result until the register is free.
module cumulative_ack_tracker_top #(
  parameter int unsigned MaxId = cat_pkg::MaxIdDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cat_ack_if.sink   ack_i,
  cat_res_if.source res_o
);

  cat_pkg::cmd_t cmd;
  cat_pkg::sts_t sts;

  cat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ack_valid_i (ack_i.valid),
    .sts_i       (sts),
    .ack_ready_o (ack_i.ready),
    .cmd_o       (cmd)
  );

  cat_dpath #(
    .MaxId (MaxId)
  ) u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .ack_id_i             (ack_i.ack_id),
    .res_ready_i          (res_o.ready),
    .res_valid_o          (res_o.valid),
    .res_max_contiguous_o (res_o.max_contiguous),
    .res_status_o         (res_o.status)
  );

endmodule
